>>> design/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg: shared types and constants for the vector normalize unit
// Opcodes, fixed point format, stage payload structs and saturation helper.
// ----------------------------------------------------------------------------
package vna_pkg;

   localparam int FRAC_BITS = 16;
   // quotient bits of one normalized component, its magnitude is at most 1.0
   localparam int QW        = FRAC_BITS + 1;
   // one root bit per cell over the 64-bit sum of squares
   localparam int SQ_CELLS  = 32;
   localparam int DIV_CELLS = QW;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_SCL  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_LEN  = 3'd4;
   localparam logic [2:0] OP_NORM = 3'd5;

   // side data that rides along the whole chain
   typedef struct packed {
      logic              is_len;
      logic              is_norm;
      logic              ovf;
      logic [2:0][31:0]  res;
      logic [2:0][31:0]  amag;
      logic [2:0]        aneg;
   } carry_type;

   typedef struct packed {
      carry_type         c;
      logic [63:0]       rad;
      logic [33:0]       rem;
      logic [31:0]       root;
   } sqrt_type;

   typedef struct packed {
      carry_type         c;
      logic [31:0]       dvs;
      logic [2:0][32:0]  rem;
      logic [2:0][QW-1:0] quo;
   } div_type;

   typedef struct packed {
      logic              ovf;
      logic [31:0]       val;
   } sat_type;

   // clamp a signed 64-bit value into the signed 32-bit range
   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r.ovf = 1'b1;
         r.val = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r.ovf = 1'b1;
         r.val = 32'h8000_0000;
      end else begin
         r.ovf = 1'b0;
         r.val = v[31:0];
      end
      return r;
   endfunction

endpackage

>>> design/vna_front.sv
// ----------------------------------------------------------------------------
// vna_front: operand stage and product/sum stage
// Multiplies, adds and saturates; seeds the square root chain.
// ----------------------------------------------------------------------------
module vna_front (
   input  logic                   clock,
   input  logic                   en1,
   input  logic                   en2,
   input  logic [2:0]             req_operation,
   input  logic signed [31:0]     req_ax,
   input  logic signed [31:0]     req_ay,
   input  logic signed [31:0]     req_az,
   input  logic signed [31:0]     req_bx,
   input  logic signed [31:0]     req_by,
   input  logic signed [31:0]     req_bz,
   input  logic signed [31:0]     req_scale_factor,
   output vna_pkg::sqrt_type      seed
);
   import vna_pkg::*;

   logic signed [31:0] a [3];
   logic signed [31:0] b [3];
   logic signed [31:0] m [3];
   logic signed [63:0] p_ff [3];
   logic signed [63:0] p_in [3];
   logic signed [32:0] s_ff [3];
   logic signed [32:0] s_in [3];
   logic [2:0]         op_ff;
   logic [2:0][31:0]   amag_ff;
   logic [2:0][31:0]   amag_in;
   logic [2:0]         aneg_ff;
   logic [2:0]         aneg_in;
   sqrt_type           seed_ff;
   sqrt_type           seed_in;

   assign a[0] = req_ax;
   assign a[1] = req_ay;
   assign a[2] = req_az;
   assign b[0] = req_bx;
   assign b[1] = req_by;
   assign b[2] = req_bz;

   // operand select and products, squares for length and normalize
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (req_operation == OP_SCL) m[i] = req_scale_factor;
         else if (req_operation == OP_MUL) m[i] = b[i];
         else m[i] = a[i];
         p_in[i] = a[i] * m[i];
         if (req_operation == OP_SUB) s_in[i] = {a[i][31], a[i]} - {b[i][31], b[i]};
         else s_in[i] = {a[i][31], a[i]} + {b[i][31], b[i]};
         aneg_in[i] = a[i][31];
         amag_in[i] = a[i][31] ? 32'(-a[i]) : 32'(a[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         for (int i = 0; i < 3; i++) begin
            p_ff[i] <= p_in[i];
            s_ff[i] <= s_in[i];
         end
         op_ff   <= req_operation;
         amag_ff <= amag_in;
         aneg_ff <= aneg_in;
      end
   end

   // shift, saturate and sum of squares
   always_comb begin
      sat_type sr;
      logic signed [63:0] v;
      seed_in = '0;
      seed_in.c.is_len  = (op_ff == OP_LEN);
      seed_in.c.is_norm = (op_ff == OP_NORM);
      seed_in.c.amag    = amag_ff;
      seed_in.c.aneg    = aneg_ff;
      seed_in.rad = 64'(p_ff[0]) + 64'(p_ff[1]) + 64'(p_ff[2]);
      for (int i = 0; i < 3; i++) begin
         if (op_ff == OP_ADD || op_ff == OP_SUB) v = 64'(s_ff[i]);
         else v = p_ff[i] >>> FRAC_BITS;
         sr = sat32(v);
         if (op_ff == OP_ADD || op_ff == OP_SUB || op_ff == OP_SCL || op_ff == OP_MUL) begin
            seed_in.c.res[i] = sr.val;
            seed_in.c.ovf    = seed_in.c.ovf | sr.ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) seed_ff <= seed_in;
   end

   assign seed = seed_ff;

endmodule

>>> design/vna_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vna_sqrt_cell: one restoring square root step
// Takes the next two radicand bits and decides one root bit.
// ----------------------------------------------------------------------------
module vna_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  vna_pkg::sqrt_type  din,
   output vna_pkg::sqrt_type  dout
);
   import vna_pkg::*;

   logic [35:0] rem_sh;
   logic [35:0] trial;
   logic        ge;
   sqrt_type    st_in;
   sqrt_type    st_ff;

   // trial subtract of 4*root+1
   always_comb begin
      rem_sh     = {din.rem, din.rad[63:62]};
      trial      = {2'b00, din.root, 2'b01};
      ge         = (rem_sh >= trial);
      st_in      = din;
      st_in.rem  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      st_in.root = {din.root[30:0], ge};
      st_in.rad  = {din.rad[61:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) st_ff <= st_in;
   end

   assign dout = st_ff;

endmodule

>>> design/vna_div_cell.sv
// ----------------------------------------------------------------------------
// vna_div_cell: one restoring division step on three lanes
// Each lane compares its remainder with the length and emits a quotient bit.
// ----------------------------------------------------------------------------
module vna_div_cell (
   input  logic              clock,
   input  logic              en,
   input  vna_pkg::div_type  din,
   output vna_pkg::div_type  dout
);
   import vna_pkg::*;

   div_type st_in;
   div_type st_ff;

   always_comb begin
      logic        ge;
      logic [32:0] diff;
      st_in = din;
      for (int i = 0; i < 3; i++) begin
         ge   = (din.rem[i] >= {1'b0, din.dvs});
         diff = ge ? din.rem[i] - {1'b0, din.dvs} : din.rem[i];
         st_in.rem[i] = {diff[31:0], 1'b0};
         st_in.quo[i] = {din.quo[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (en) st_ff <= st_in;
   end

   assign dout = st_ff;

endmodule

>>> design/vector3_alu_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_alu_normalize_core: three-component Q16.16 vector unit
// Add, subtract, scale, multiply, length and normalize on one pipeline.
// ----------------------------------------------------------------------------
// Stages from accepted beat to result: two front stages, one square root cell
// per root bit, one divider cell per quotient bit, then the output register.
// Throughput: one beat per cycle while rsp_stall is low; each stage moves
// when the next one is free.
// Reset empties every stage; data registers are not cleared.
module vector3_alu_normalize_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic signed [31:0] req_ax,
   input  logic signed [31:0] req_ay,
   input  logic signed [31:0] req_az,
   input  logic signed [31:0] req_bx,
   input  logic signed [31:0] req_by,
   input  logic signed [31:0] req_bz,
   input  logic signed [31:0] req_scale_factor,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_rx,
   output logic signed [31:0] rsp_ry,
   output logic signed [31:0] rsp_rz,
   output logic [31:0]        rsp_magnitude,
   output logic               rsp_zero_length,
   output logic               rsp_overflow
);
   import vna_pkg::*;

   localparam int NST = 2 + SQ_CELLS + DIV_CELLS + 1;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] v_in;
   logic [NST-1:0] en;
   sqrt_type       sq [SQ_CELLS+1];
   div_type        dv [DIV_CELLS+1];
   logic [2:0][31:0] r_ff;
   logic [2:0][31:0] r_in;
   logic [31:0]    mag_ff;
   logic [31:0]    mag_in;
   logic           zl_ff;
   logic           zl_in;
   logic           ovf_ff;
   logic           ovf_in;

   // stage enables: a stage loads when it is empty or its neighbor moves on
   always_comb begin
      en[NST-1] = !v_ff[NST-1] || !rsp_stall;
      for (int i = NST-2; i >= 0; i--) en[i] = !v_ff[i] || en[i+1];
      v_in[0] = en[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NST; i++) v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= v_in;
   end

   assign req_stall = !en[0];

   vna_front u_front (
      .clock            (clock),
      .en1              (en[0]),
      .en2              (en[1]),
      .req_operation    (req_operation),
      .req_ax           (req_ax),
      .req_ay           (req_ay),
      .req_az           (req_az),
      .req_bx           (req_bx),
      .req_by           (req_by),
      .req_bz           (req_bz),
      .req_scale_factor (req_scale_factor),
      .seed             (sq[0])
   );

   // square root chain
   for (genvar g = 0; g < SQ_CELLS; g++) begin : g_sqrt
      vna_sqrt_cell u_cell (
         .clock (clock),
         .en    (en[2+g]),
         .din   (sq[g]),
         .dout  (sq[g+1])
      );
   end

   // divider seed: remainder starts at the component magnitude
   always_comb begin
      dv[0].c   = sq[SQ_CELLS].c;
      dv[0].dvs = sq[SQ_CELLS].root;
      for (int i = 0; i < 3; i++) begin
         dv[0].rem[i] = {1'b0, sq[SQ_CELLS].c.amag[i]};
         dv[0].quo[i] = '0;
      end
   end

   for (genvar g = 0; g < DIV_CELLS; g++) begin : g_div
      vna_div_cell u_cell (
         .clock (clock),
         .en    (en[2+SQ_CELLS+g]),
         .din   (dv[g]),
         .dout  (dv[g+1])
      );
   end

   // result select and sign of normalized components
   always_comb begin
      logic [31:0] qv;
      zl_in  = dv[DIV_CELLS].c.is_norm && (dv[DIV_CELLS].dvs == '0);
      ovf_in = dv[DIV_CELLS].c.ovf;
      mag_in = (dv[DIV_CELLS].c.is_len || dv[DIV_CELLS].c.is_norm) ?
               dv[DIV_CELLS].dvs : '0;
      for (int i = 0; i < 3; i++) begin
         qv = 32'(dv[DIV_CELLS].quo[i]);
         if (dv[DIV_CELLS].c.is_norm) begin
            if (zl_in) r_in[i] = '0;
            else r_in[i] = dv[DIV_CELLS].c.aneg[i] ? 32'(-qv) : qv;
         end else begin
            r_in[i] = dv[DIV_CELLS].c.res[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NST-1]) begin
         r_ff   <= r_in;
         mag_ff <= mag_in;
         zl_ff  <= zl_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid       = v_ff[NST-1];
   assign rsp_rx          = r_ff[0];
   assign rsp_ry          = r_ff[1];
   assign rsp_rz          = r_ff[2];
   assign rsp_magnitude   = mag_ff;
   assign rsp_zero_length = zl_ff;
   assign rsp_overflow    = ovf_ff;

   // zero-length beat carries a zero vector, zero magnitude and no saturation
   a_zero_len : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_magnitude == 0 && rsp_rx == 0 && rsp_ry == 0 && rsp_rz == 0 && !rsp_overflow)
      else $error("zero-length result not clean");

   // an empty first stage always takes a beat
   a_take : assert property (@(posedge clock) disable iff (reset)
      !v_ff[0] |-> !req_stall)
      else $error("stall with empty entry stage");

   // reset empties the pipeline
   a_reset : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result stays in place while stalled
   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rx) && $stable(rsp_magnitude))
      else $error("stalled result moved");

endmodule

>>> tb/tb_vector3_alu_normalize_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector3_alu_normalize_core: self-checking bench for the vector unit
// Drives directed and random vector beats through the valid/stall channels
// under several idle patterns, predicts each result in a scoreboard and
// compares every returned beat field by field in order.
// ----------------------------------------------------------------------------

module tb_vector3_alu_normalize_core;
   import vna_pkg::*;

   // opcodes the unit leaves unused
   localparam logic [2:0] OP_UNUSED_6 = 3'd6;
   localparam logic [2:0] OP_UNUSED_7 = 3'd7;

   typedef struct {
      logic [31:0] rx;
      logic [31:0] ry;
      logic [31:0] rz;
      logic [31:0] magnitude;
      logic        zero_length;
      logic        overflow;
   } vec_result_type;

   class vec_scoreboard;
      vec_result_type pending[$];
      int             errors;

      // clamp to signed 32 bits, noting overflow
      static function logic [31:0] clamp(input longint v, inout logic ovf);
         if (v > 64'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
         end
         if (v < -64'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
         end
         return v[31:0];
      endfunction

      // fixed point product, floor of the shifted result
      static function longint fx_product(input longint a, input longint b);
         longint p;
         p = a * b;
         return p >>> FRAC_BITS;
      endfunction

      static function longint unsigned int_sqrt(input longint unsigned n);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv >>= 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      // predict the result of one accepted input beat
      function void note_input(input logic [2:0] op, input logic [31:0] a[3],
                               input logic [31:0] b[3], input logic [31:0] k);
         vec_result_type  e;
         longint          av, bv, kv, v;
         longint unsigned s, m, len, q;
         logic            ovf;
         logic [31:0]     r[3];
         ovf = 1'b0;
         s = 0;
         len = 0;
         kv = longint'($signed(k));
         for (int i = 0; i < 3; i++) r[i] = '0;
         if (op inside {OP_ADD, OP_SUB, OP_SCL, OP_MUL}) begin
            for (int i = 0; i < 3; i++) begin
               av = longint'($signed(a[i]));
               bv = longint'($signed(b[i]));
               case (op)
                  OP_ADD: v = av + bv;
                  OP_SUB: v = av - bv;
                  OP_SCL: v = fx_product(av, kv);
                  default: v = fx_product(av, bv);
               endcase
               r[i] = clamp(v, ovf);
            end
         end else if (op == OP_LEN || op == OP_NORM) begin
            for (int i = 0; i < 3; i++) begin
               av = longint'($signed(a[i]));
               m = (av < 0) ? longint'(-av) : av;
               s += m * m;
            end
            len = int_sqrt(s);
            if (op == OP_NORM && len != 0) begin
               for (int i = 0; i < 3; i++) begin
                  av = longint'($signed(a[i]));
                  m = (av < 0) ? longint'(-av) : av;
                  q = (m << FRAC_BITS) / len;
                  v = (av < 0) ? -longint'(q) : longint'(q);
                  r[i] = clamp(v, ovf);
               end
            end
         end
         e.rx = r[0];
         e.ry = r[1];
         e.rz = r[2];
         e.magnitude = len[31:0];
         e.zero_length = (op == OP_NORM && len == 0);
         e.overflow = ovf;
         pending.push_back(e);
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         errors++;
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      endtask

      // compare one result beat with the oldest prediction
      task check_result(input vec_result_type got);
         vec_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("unexpected result beat at %0t", $time);
            return;
         end
         e = pending.pop_front();
         if (got.rx !== e.rx) report("rx", got.rx, e.rx);
         if (got.ry !== e.ry) report("ry", got.ry, e.ry);
         if (got.rz !== e.rz) report("rz", got.rz, e.rz);
         if (got.magnitude !== e.magnitude) report("magnitude", got.magnitude, e.magnitude);
         if (got.zero_length !== e.zero_length)
            report("zero_length", got.zero_length, e.zero_length);
         if (got.overflow !== e.overflow) report("overflow", got.overflow, e.overflow);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_operation;
   logic signed [31:0] req_ax, req_ay, req_az, req_bx, req_by, req_bz;
   logic signed [31:0] req_scale_factor;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_rx, rsp_ry, rsp_rz;
   logic [31:0]        rsp_magnitude;
   logic               rsp_zero_length;
   logic               rsp_overflow;

   int send_idle_pct;
   int recv_stall_pct;

   vec_scoreboard board;

   vector3_alu_normalize_core i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("timeout at %0t", $time);
      $display("tb_vector3_alu_normalize_core failed");
      $finish;
   end

   // receiver side: random stall, check each accepted beat
   always @(posedge clock) begin
      vec_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.rx = rsp_rx;
         got.ry = rsp_ry;
         got.rz = rsp_rz;
         got.magnitude = rsp_magnitude;
         got.zero_length = rsp_zero_length;
         got.overflow = rsp_overflow;
         board.check_result(got);
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // drive one beat, holding it until accepted
   task send_vector(input logic [2:0] op, input logic [31:0] a[3],
                    input logic [31:0] b[3], input logic [31:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_ax <= a[0];
      req_ay <= a[1];
      req_az <= a[2];
      req_bx <= b[0];
      req_by <= b[1];
      req_bz <= b[2];
      req_scale_factor <= k;
      do @(posedge clock); while (req_stall);
      board.note_input(op, a, b, k);
   endtask

   // mix of extremes, small values and full range
   function logic [31:0] pick_value();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF - $urandom_range(3);
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return $urandom_range(4);
         3: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   task send_random();
      logic [31:0] a[3], b[3];
      logic [2:0]  op;
      op = 3'($urandom_range(7));
      for (int i = 0; i < 3; i++) begin
         a[i] = pick_value();
         b[i] = pick_value();
      end
      if ($urandom_range(9) == 0) a = '{0, 0, 0};
      send_vector(op, a, b, pick_value());
   endtask

   task drain();
      int n;
      n = 0;
      req_valid <= 1'b0;
      while (board.pending.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
   endtask

   initial begin
      logic [31:0] mx, mn, one;
      board = new();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = '0;
      {req_ax, req_ay, req_az, req_bx, req_by, req_bz, req_scale_factor} = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      mx = 32'h7FFF_FFFF;
      mn = 32'h8000_0000;
      one = 32'h0001_0000;

      // directed: extremes, every opcode, zero vector, unused codes
      send_vector(OP_ADD, '{mx, mn, one}, '{mx, mn, one}, 0);
      send_vector(OP_ADD, '{mx, mn, 0}, '{mn, mx, 0}, 0);
      send_vector(OP_SUB, '{mn, mx, one}, '{mx, mn, one}, 0);
      send_vector(OP_SUB, '{0, 0, 0}, '{mn, mx, 1}, 0);
      send_vector(OP_SCL, '{mx, mn, one}, '{0, 0, 0}, mx);
      send_vector(OP_SCL, '{mn, mn, 32'hFFFF_FFFF}, '{0, 0, 0}, mn);
      send_vector(OP_SCL, '{one, 32'hFFFF_FFFF, 3}, '{0, 0, 0}, one);
      send_vector(OP_MUL, '{mx, mn, 32'hFFFF_FFFF}, '{mx, mn, 1}, 0);
      send_vector(OP_MUL, '{one, 32'hFFFF_0000, 5}, '{one, one, 32'hFFFF_FFFF}, 0);
      send_vector(OP_LEN, '{mn, mn, mn}, '{0, 0, 0}, 0);
      send_vector(OP_LEN, '{mx, mx, mx}, '{0, 0, 0}, 0);
      send_vector(OP_LEN, '{one, 0, 0}, '{0, 0, 0}, 0);
      send_vector(OP_LEN, '{0, 0, 0}, '{mx, mx, mx}, mx);
      send_vector(OP_NORM, '{0, 0, 0}, '{mx, mn, 1}, mx);
      send_vector(OP_NORM, '{mn, 0, 0}, '{0, 0, 0}, 0);
      send_vector(OP_NORM, '{mx, mn, mx}, '{0, 0, 0}, 0);
      send_vector(OP_NORM, '{1, 0, 0}, '{0, 0, 0}, 0);
      send_vector(OP_NORM, '{0, 32'hFFFF_FFFF, 1}, '{0, 0, 0}, 0);
      send_vector(OP_UNUSED_6, '{mx, mn, one}, '{mx, mn, one}, mx);
      send_vector(OP_UNUSED_7, '{mn, mx, one}, '{mn, mx, one}, mn);

      // random phases with several idle patterns
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
            3: begin send_idle_pct = 10; recv_stall_pct = 10; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         for (int n = 0; n < 290; n++) send_random();
      end
      drain();
      if (board.errors == 0 && board.pending.size() == 0)
         $display("tb_vector3_alu_normalize_core passed");
      else
         $display("tb_vector3_alu_normalize_core failed");
      $finish;
   end
endmodule
